FILE: design/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned START_W = 32;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned STEP_W  = 12;
    localparam int unsigned CFG_W   = 13;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_STEP = 1'b1;

    // Operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [SIZE_W-1:0] RESET_TABLE_SIZE = 13'd4093;
    localparam logic [STEP_W-1:0] RESET_PROBE_STEP = 12'd1013;

    // One slot as stored in the table memory. The valid bit marks a used slot.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] start;
    } slot_t;

    localparam int unsigned SLOT_W = 1 + KEY_W + COUNT_W + START_W;

endpackage

FILE: design/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Hash table with fixed-step linear probing, insert and lookup operations.
// ----------------------------------------------------------------------------
// One word is processed at a time. After reset the block clears the slot
// memory and holds s_tready low meanwhile. A word then has key modulo size
// and step modulo size computed (a shared one-bit-per-cycle restoring
// divider), each probed slot read from memory and then compared, the probe
// stopped at the read step when the whole table was probed without an
// outcome, and the output register loaded before the block returns to
// idle for the next word. Slot contents and their valid bits live in one
// registered-read RAM. The output register parts the two sides: a new word
// is accepted while the previous result waits, and only the load of the
// next result waits for the receiver.
module open_addressing_hash_table #(
    parameter int unsigned TABLE_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: key[31:0], count[47:32], zero pad [55:48]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // tuser: operation[0]
    input  logic        s_tuser,
    // tdata: found[0], entry_count[16:1], start_index[48:17], table_full[49],
    // zero pad [55:50]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [oaht_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [oaht_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    // Size values run up to TABLE_DEPTH, one bit wider than an address.
    localparam int unsigned SW = AW + 1;
    localparam int unsigned DIV_W = 32;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV_KEY, ST_DIV_STEP, ST_READ, ST_CHECK, ST_OUT
    } state_t;

    // Configuration registers.
    logic [oaht_pkg::SIZE_W-1:0] table_size_reg;
    logic [oaht_pkg::STEP_W-1:0] probe_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= oaht_pkg::RESET_TABLE_SIZE;
            probe_step_reg <= oaht_pkg::RESET_PROBE_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                oaht_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_wr_data;
                oaht_pkg::CFG_PROBE_STEP:
                    probe_step_reg <= cfg_wr_data[oaht_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective size, clamped to 1..TABLE_DEPTH.
    logic [SW-1:0] eff_size;
    always_comb begin
        if (table_size_reg == '0) begin
            eff_size = SW'(1);
        end else if (32'(table_size_reg) > 32'(TABLE_DEPTH)) begin
            eff_size = SW'(TABLE_DEPTH);
        end else begin
            eff_size = SW'(table_size_reg);
        end
    end

    state_t state_reg;
    logic                           op_reg;
    logic [oaht_pkg::KEY_W-1:0]     key_reg;
    logic [oaht_pkg::COUNT_W-1:0]   cnt_reg;
    logic [SW-1:0]                  size_reg;
    logic [DIV_W-1:0]               quot_reg;   // dividend bits shifting out
    logic [SW-1:0]                  rem_reg;
    logic [5:0]                     bit_cnt_reg;
    logic [AW-1:0]                  loc_reg;
    logic [AW-1:0]                  clr_addr_reg;
    logic [SW-1:0]                  step_reg;
    logic [SW-1:0]                  visits_reg;
    logic [oaht_pkg::START_W-1:0]   next_start_reg;
    logic                           m_valid_reg;
    logic [55:0]                    m_data_reg;
    logic                           res_found_reg;
    logic [oaht_pkg::COUNT_W-1:0]   res_count_reg;
    logic [oaht_pkg::START_W-1:0]   res_start_reg;
    logic                           res_full_reg;

    // Restoring divider step: one quotient bit per cycle.
    logic [SW:0]   div_trial;
    logic [SW-1:0] div_rem_next;
    always_comb begin
        div_trial = {rem_reg, quot_reg[DIV_W-1]};
        if (div_trial >= {1'b0, size_reg}) begin
            div_rem_next = SW'(div_trial - {1'b0, size_reg});
        end else begin
            div_rem_next = SW'(div_trial);
        end
    end

    // Slot memory.
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    oaht_pkg::slot_t         ram_wr_data;
    oaht_pkg::slot_t         ram_rd_data;
    logic [oaht_pkg::SLOT_W-1:0] ram_rd_bits;

    assign ram_rd_data = oaht_pkg::slot_t'(ram_rd_bits);

    oaht_ram #(
        .WIDTH(oaht_pkg::SLOT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (loc_reg),
        .rd_data (ram_rd_bits)
    );

    // Probe decision for the slot read in the previous cycle, and the memory
    // write port, shared by the clearing pass and inserts.
    logic          slot_free;
    logic          key_hit;
    logic [SW:0]   loc_sum;
    logic [AW-1:0] loc_adv;
    always_comb begin
        slot_free = !ram_rd_data.valid;
        key_hit   = (op_reg == oaht_pkg::OP_LOOKUP) && (ram_rd_data.key == key_reg);
        loc_sum   = {2'b00, loc_reg} + {1'b0, step_reg};
        if (loc_sum >= {1'b0, size_reg}) begin
            loc_adv = AW'(loc_sum - {1'b0, size_reg});
        end else begin
            loc_adv = AW'(loc_sum);
        end
        if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = (state_reg == ST_CHECK) && slot_free &&
                          (op_reg == oaht_pkg::OP_INSERT);
            ram_wr_addr = loc_reg;
            ram_wr_data.valid = 1'b1;
            ram_wr_data.key   = key_reg;
            ram_wr_data.count = cnt_reg;
            ram_wr_data.start = next_start_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Control sequencer and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            next_start_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == AW'(TABLE_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        op_reg      <= s_tuser;
                        key_reg     <= s_tdata[31:0];
                        cnt_reg     <= s_tdata[47:32];
                        size_reg    <= eff_size;
                        quot_reg    <= s_tdata[31:0];
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        state_reg   <= ST_DIV_KEY;
                    end
                end
                ST_DIV_KEY: begin
                    if (bit_cnt_reg == 6'(DIV_W - 1)) begin
                        loc_reg     <= AW'(div_rem_next);
                        rem_reg     <= '0;
                        quot_reg    <= {probe_step_reg, 20'd0};
                        bit_cnt_reg <= '0;
                        state_reg   <= ST_DIV_STEP;
                    end else begin
                        rem_reg     <= div_rem_next;
                        quot_reg    <= {quot_reg[DIV_W-2:0], 1'b0};
                        bit_cnt_reg <= bit_cnt_reg + 6'd1;
                    end
                end
                ST_DIV_STEP: begin
                    rem_reg     <= div_rem_next;
                    quot_reg    <= {quot_reg[DIV_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + 6'd1;
                    if (bit_cnt_reg == 6'(oaht_pkg::STEP_W - 1)) begin
                        step_reg   <= div_rem_next;
                        visits_reg <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (visits_reg == size_reg) begin
                        res_found_reg <= 1'b0;
                        res_count_reg <= '0;
                        res_start_reg <= '0;
                        res_full_reg  <= 1'b1;
                        state_reg     <= ST_OUT;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (slot_free) begin
                        res_full_reg <= 1'b0;
                        if (op_reg == oaht_pkg::OP_INSERT) begin
                            res_found_reg  <= 1'b1;
                            res_count_reg  <= cnt_reg;
                            res_start_reg  <= next_start_reg;
                            next_start_reg <= next_start_reg + 32'(cnt_reg);
                        end else begin
                            res_found_reg <= 1'b0;
                            res_count_reg <= '0;
                            res_start_reg <= '0;
                        end
                        state_reg <= ST_OUT;
                    end else if (key_hit) begin
                        res_found_reg <= 1'b1;
                        res_count_reg <= ram_rd_data.count;
                        res_start_reg <= ram_rd_data.start;
                        res_full_reg  <= 1'b0;
                        state_reg     <= ST_OUT;
                    end else begin
                        loc_reg    <= loc_adv;
                        visits_reg <= visits_reg + SW'(1);
                        state_reg  <= ST_READ;
                    end
                end
                ST_OUT: begin
                    // Load the output register once the previous word is gone.
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, res_full_reg, res_start_reg,
                                        res_count_reg, res_found_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A waiting result word holds steady until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("result changed before taken");

    // The probe location stays inside the table in use whenever a slot is checked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> ({1'b0, loc_reg} < size_reg))
        else $error("probe location out of range");

    // No word is taken while the slot memory is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("word accepted during clearing pass");

    // A full-table result never reports a found entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[49]) |-> !m_data_reg[0])
        else $error("full and found both set");

endmodule
